// ----- rtl/mgh_pkg.sv -----
// ----------------------------------------------------------------------------
// mgh_pkg
// Shared constants, types and helpers of the match gap histogram block.
// ----------------------------------------------------------------------------
package mgh_pkg;

  localparam int NUM_BINS = 131072;
  localparam int BIN_AW   = $clog2(NUM_BINS);
  localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(NUM_BINS - 1);

  localparam int VOXEL_W = 16;
  localparam int INDEX_W = 17;
  localparam int COUNT_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // request codes
  localparam logic ACT_FEED = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // configuration port
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_TYPE = REG_IDX_W'(0);

  // result queue, power-of-two depth so the pointers wrap
  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_FIFO_AW    = $clog2(RES_FIFO_DEPTH);
  localparam int RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] total_matches;
  } res_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/mgh_if.sv -----
// ----------------------------------------------------------------------------
// mgh_if
// Valid/ready channels for requests into and results out of the block.
// ----------------------------------------------------------------------------
interface mgh_in_if;
  import mgh_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [VOXEL_W-1:0] voxel_value;
  logic [INDEX_W-1:0] bin_index;

  modport source (output valid, output action, output voxel_value, output bin_index,
                  input ready);
  modport sink   (input valid, input action, input voxel_value, input bin_index,
                  output ready);
endinterface

interface mgh_out_if;
  import mgh_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] bin_count;
  logic [COUNT_W-1:0] total_matches;

  modport source (output valid, output bin_count, output total_matches, input ready);
  modport sink   (input valid, input bin_count, input total_matches, output ready);
endinterface

// ----- rtl/mgh_ram.sv -----
// ----------------------------------------------------------------------------
// mgh_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mgh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mgh_cfg.sv -----
// ----------------------------------------------------------------------------
// mgh_cfg
// APB register file holding the target voxel type.
// ----------------------------------------------------------------------------
module mgh_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mgh_pkg::APB_AW-1:0]  paddr,
  input  logic [mgh_pkg::APB_DW-1:0]  pwdata,
  output logic [mgh_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [mgh_pkg::VOXEL_W-1:0] target_type
);
  import mgh_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_type <= '0;
    end else if (wr && reg_idx == REG_TARGET_TYPE) begin
      target_type <= pwdata[VOXEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_TARGET_TYPE) begin
      prdata = APB_DW'(target_type);
    end
  end

endmodule

// ----- rtl/mgh_core.sv -----
// ----------------------------------------------------------------------------
// mgh_core
// Gap counter, match total and histogram read-modify-write pipeline.
// ----------------------------------------------------------------------------
module mgh_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mgh_pkg::VOXEL_W-1:0]   target_type,
  mgh_in_if.sink                        in_ch,
  input  logic [mgh_pkg::RES_CNT_W-1:0] fifo_count,
  output logic                          push,
  output mgh_pkg::res_t                 push_data
);
  import mgh_pkg::*;

  logic               clearing;
  logic [BIN_AW-1:0]  clear_addr;
  logic [BIN_AW-1:0]  gap, gap_next, gap_base;
  logic [COUNT_W-1:0] match_total, match_total_next;

  logic               accept, is_feed, hit, in_range, rd_en;
  logic [BIN_AW-1:0]  rd_addr;
  logic [RES_CNT_W-1:0] occ;

  // second stage: ram data returns here
  logic               s1_valid, s1_read, s1_write, s1_fwd, s1_zero;
  logic [BIN_AW-1:0]  s1_addr;
  logic [COUNT_W-1:0] s1_total;
  logic [COUNT_W-1:0] wr_data_q;

  logic [COUNT_W-1:0] ram_rdata, cur, inc;
  logic               we;
  logic [BIN_AW-1:0]  waddr;
  logic [COUNT_W-1:0] wdata;

  // reserve a result slot for every read in flight
  assign occ = fifo_count + {{(RES_CNT_W-1){1'b0}}, s1_valid && s1_read};
  assign in_ch.ready = !clearing && (occ < RES_CNT_W'(RES_FIFO_DEPTH));
  assign accept = in_ch.valid && in_ch.ready;

  assign is_feed  = in_ch.action == ACT_FEED;
  assign hit      = is_feed && (in_ch.voxel_value == target_type);
  assign in_range = 32'(in_ch.bin_index) < 32'(NUM_BINS);
  assign rd_addr  = is_feed ? gap : BIN_AW'(in_ch.bin_index);
  assign rd_en    = accept && (hit || (!is_feed && in_range));

  always_comb begin
    gap_base = hit ? '0 : gap;
    gap_next = gap;
    match_total_next = match_total;
    if (accept && is_feed) begin
      gap_next = (gap_base < LAST_BIN) ? gap_base + 1'b1 : gap_base;
    end
    if (accept && hit) begin
      match_total_next = sat_inc(match_total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clear_addr  <= '0;
      gap         <= '0;
      match_total <= '0;
      s1_valid    <= 1'b0;
      s1_read     <= 1'b0;
      s1_write    <= 1'b0;
      s1_fwd      <= 1'b0;
    end else begin
      if (clearing) begin
        if (clear_addr == LAST_BIN) begin
          clearing <= 1'b0;
        end else begin
          clear_addr <= clear_addr + 1'b1;
        end
      end
      gap         <= gap_next;
      match_total <= match_total_next;
      s1_valid    <= accept;
      s1_read     <= accept && !is_feed;
      s1_write    <= accept && hit;
      // bin being written back now is read again by this request
      s1_fwd      <= s1_valid && s1_write && (s1_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= rd_addr;
    s1_zero  <= !in_range;
    s1_total <= match_total;
    if (s1_valid && s1_write) begin
      wr_data_q <= inc;
    end
  end

  assign cur = s1_fwd ? wr_data_q : ram_rdata;
  assign inc = sat_inc(cur);

  assign we    = clearing || (s1_valid && s1_write);
  assign waddr = clearing ? clear_addr : s1_addr;
  assign wdata = clearing ? '0 : inc;

  mgh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign push                    = s1_valid && s1_read;
  assign push_data.bin_count     = s1_zero ? '0 : cur;
  assign push_data.total_matches = s1_total;

`ifndef SYNTH
  a_slot_reserved: assert property (@(posedge clk) disable iff (rst)
    push |-> fifo_count < RES_CNT_W'(RES_FIFO_DEPTH))
    else $error("result pushed without a free slot");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> $past(s1_valid && s1_write))
    else $error("forward taken without a preceding write-back");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !accept)
    else $error("request in flight during histogram clear");
`endif

endmodule

// ----- rtl/mgh_res_fifo.sv -----
// ----------------------------------------------------------------------------
// mgh_res_fifo
// Small result queue that decouples the pipeline from the output side.
// ----------------------------------------------------------------------------
module mgh_res_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  mgh_pkg::res_t                 push_data,
  output logic [mgh_pkg::RES_CNT_W-1:0] count,
  mgh_out_if.source                     out_ch
);
  import mgh_pkg::*;

  res_t                   entries [RES_FIFO_DEPTH];
  logic [RES_FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic                   pop;

  assign out_ch.valid         = count != '0;
  assign out_ch.bin_count     = entries[rd_ptr].bin_count;
  assign out_ch.total_matches = entries[rd_ptr].total_matches;
  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < RES_CNT_W'(RES_FIFO_DEPTH))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RES_FIFO_DEPTH))
    else $error("result queue count out of range");
`endif

endmodule

// ----- rtl/match_gap_histogram_top.sv -----
// one request accepted per cycle while no clear runs and a result slot is free;
// feed requests with a match do a read-modify-write of one histogram bin,
// forwarded when back to back; a read's result goes via s1 and the result
// queue; the histogram memory's single write port sets the one-per-cycle rate
// after reset a clearing pass writes all 131072 bins, one per cycle,
// and no request is accepted until it ends; register writes work throughout
// ----------------------------------------------------------------------------
// match_gap_histogram_top
// Histogram of distances between occurrences of a target voxel type.
// ----------------------------------------------------------------------------
module match_gap_histogram_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mgh_pkg::APB_AW-1:0]  paddr,
  input  logic [mgh_pkg::APB_DW-1:0]  pwdata,
  output logic [mgh_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  mgh_in_if.sink                      in_ch,
  mgh_out_if.source                   out_ch
);
  import mgh_pkg::*;

  logic [VOXEL_W-1:0]   target_type;
  logic [RES_CNT_W-1:0] fifo_count;
  logic                 push;
  res_t                 push_data;

  mgh_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .target_type (target_type)
  );

  mgh_core u_core (
    .clk         (clk),
    .rst         (rst),
    .target_type (target_type),
    .in_ch       (in_ch),
    .fifo_count  (fifo_count),
    .push        (push),
    .push_data   (push_data)
  );

  mgh_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .count     (fifo_count),
    .out_ch    (out_ch)
  );

endmodule
